[hdl/sorted_priority_queue_defines.svh]
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq: implication check failed");

// Next-cycle implication, disabled while in reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq: next-cycle check failed");

`endif

[hdl/spq_pkg.sv]
// Shared constants, codes and types of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;
	localparam int unsigned DEPTH_DEF       = 16;
	localparam int unsigned PRIO_LEVELS_DEF = 16;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PRIO_W  = 4;
	localparam int unsigned COUNT_W = 5;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [PRIO_W-1:0]         prio_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef struct packed {
		logic load;
		logic enq;
		logic deq;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sts_t;
endpackage

[hdl/spq_if.sv]
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
interface spq_req_if;
	import spq_pkg::*;
	logic   valid;
	logic   ready;
	logic   action;
	value_t value;
	prio_t  priority_req;

	modport source (output valid, output action, output value, output priority_req,
		input ready);
	modport sink (input valid, input action, input value, input priority_req,
		output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic   valid;
	logic   ready;
	logic   ok;
	value_t out_value;
	prio_t  out_priority;
	count_t entry_count;
	logic   is_empty;

	modport source (output valid, output ok, output out_value, output out_priority,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input ok, input out_value, input out_priority,
		input entry_count, input is_empty, output ready);
endinterface

[hdl/spq_ctrl.sv]
// Controller: beat acceptance, result-register occupancy and datapath commands.
`timescale 1ns / 1ps
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);
	import spq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic st_q;
	logic st_d;
	logic accept;

	assign in_ready  = (st_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (st_q == ST_HOLD);

	always_comb begin
		cmd.load = accept;
		cmd.enq  = accept && (in_action == ACT_ENQ) && !sts.full;
		cmd.deq  = accept && (in_action == ACT_DEQ) && !sts.empty;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) st_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (accept) st_d = ST_HOLD;
				else if (out_ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end
endmodule

[hdl/spq_datapath.sv]
// Datapath: sorted shift-register cells, entry counter and result register.
`timescale 1ns / 1ps
module spq_datapath #(
	parameter int unsigned DEPTH           = spq_pkg::DEPTH_DEF,
	parameter int unsigned PRIORITY_LEVELS = spq_pkg::PRIO_LEVELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::cmd_t   cmd,
	output spq_pkg::sts_t   sts,
	input  spq_pkg::value_t in_value,
	input  spq_pkg::prio_t  in_priority,
	output logic            ok,
	output spq_pkg::value_t out_value,
	output spq_pkg::prio_t  out_priority,
	output spq_pkg::count_t entry_count,
	output logic            is_empty
);
	import spq_pkg::*;

	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned PMAX = (PRIORITY_LEVELS > (1 << PRIO_W)) ?
		((1 << PRIO_W) - 1) : (PRIORITY_LEVELS - 1);

	value_t         val_q [DEPTH];
	prio_t          pri_q [DEPTH];
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_d;
	prio_t          p_sat;
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] ge_prev;
	value_t         enq_src_val [DEPTH];
	prio_t          enq_src_pri [DEPTH];
	value_t         deq_src_val [DEPTH];
	prio_t          deq_src_pri [DEPTH];

	logic   ok_q;
	value_t oval_q;
	prio_t  opri_q;
	count_t ocnt_q;
	logic   oempty_q;

	assign p_sat = (32'(in_priority) > PMAX) ? PRIO_W'(PMAX) : in_priority;

	assign sts.full  = (cnt_q == CW'(DEPTH));
	assign sts.empty = (cnt_q == '0);

	// ge: cell holds a live entry that stays ahead of the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CW'(i) < cnt_q) && (pri_q[i] >= p_sat);
		end
		ge_prev[0]     = 1'b1;
		enq_src_val[0] = in_value;
		enq_src_pri[0] = p_sat;
		for (int i = 1; i < DEPTH; i++) begin
			ge_prev[i]     = ge[i-1];
			enq_src_val[i] = ge[i-1] ? in_value : val_q[i-1];
			enq_src_pri[i] = ge[i-1] ? p_sat : pri_q[i-1];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			deq_src_val[i] = val_q[i+1];
			deq_src_pri[i] = pri_q[i+1];
		end
		deq_src_val[DEPTH-1] = val_q[DEPTH-1];
		deq_src_pri[DEPTH-1] = pri_q[DEPTH-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.enq && !ge[i]) begin
				val_q[i] <= ge_prev[i] ? in_value : enq_src_val[i];
				pri_q[i] <= ge_prev[i] ? p_sat : enq_src_pri[i];
			end else if (cmd.deq) begin
				val_q[i] <= deq_src_val[i];
				pri_q[i] <= deq_src_pri[i];
			end
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.enq) cnt_d = cnt_q + CW'(1);
		else if (cmd.deq) cnt_d = cnt_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q     <= cmd.enq || cmd.deq;
			oval_q   <= cmd.deq ? val_q[0] : '0;
			opri_q   <= cmd.deq ? pri_q[0] : '0;
			ocnt_q   <= COUNT_W'(cnt_d);
			oempty_q <= (cnt_d == '0);
		end
	end

	assign ok           = ok_q;
	assign out_value    = oval_q;
	assign out_priority = opri_q;
	assign entry_count  = ocnt_q;
	assign is_empty     = oempty_q;
endmodule

[hdl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: controller, datapath and checks.
//
//   channel  dir  payload                                               
//   req      in   action, value, priority_req                           
//   rsp      out  ok, out_value, out_priority, entry_count, is_empty    
//
// One beat per cycle unless rsp stalls: a request is applied to the sorted cell
// array when accepted and its result sits in the output register next cycle.
// req.ready stays high while the result register is empty or being drained.
// Reset clears the entry count and the result-valid state; cells are not cleared.
// A stalled rsp holds its beat and blocks further requests.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"
module sorted_priority_queue #(
	parameter int unsigned DEPTH           = spq_pkg::DEPTH_DEF,
	parameter int unsigned PRIORITY_LEVELS = spq_pkg::PRIO_LEVELS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH           (DEPTH),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_value     (req.value),
		.in_priority  (req.priority_req),
		.ok           (rsp.ok),
		.out_value    (rsp.out_value),
		.out_priority (rsp.out_priority),
		.entry_count  (rsp.entry_count),
		.is_empty     (rsp.is_empty)
	);

	`SPQ_ASSERT_NEXT(a_beat_gives_result, clk, arst_n, req.valid && req.ready, rsp.valid)
	`SPQ_ASSERT_NEXT(a_deq_empty_fails, clk, arst_n, req.valid && req.ready && req.action == ACT_DEQ && sts.empty, !rsp.ok && rsp.out_value == '0 && rsp.is_empty)
	`SPQ_ASSERT_NEXT(a_enq_full_refused, clk, arst_n, req.valid && req.ready && req.action == ACT_ENQ && sts.full, !rsp.ok && sts.full)
	`SPQ_ASSERT_IMP(a_empty_count, clk, arst_n, rsp.valid && rsp.is_empty, rsp.entry_count == '0)
endmodule

[dv/sorted_priority_queue_tb.sv]
// Testbench for the sorted priority queue: directed and random traffic with predicted responses.
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int QDEPTH       = DEPTH_DEF;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_CAP    = 50;

	typedef struct {
		logic   ok;
		value_t out_value;
		prio_t  out_priority;
		count_t entry_count;
		logic   is_empty;
	} spq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	value_t      shadow_values [QDEPTH];
	prio_t       shadow_prios [QDEPTH];
	int          shadow_count = 0;
	spq_result_t awaited_responses [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	always #5 clk = ~clk;

	// Sorted insert behind equal or higher priorities; dequeue takes the head.
	function automatic spq_result_t apply_queue_op(input logic act, input value_t v,
		input prio_t p);
		spq_result_t r;
		int pos;
		r = '{ok: 1'b0, out_value: '0, out_priority: '0, entry_count: '0, is_empty: 1'b0};
		if (act == ACT_ENQ) begin
			if (shadow_count < QDEPTH) begin
				pos = shadow_count;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_prios[i] < p && pos == shadow_count)
						pos = i;
				end
				for (int i = shadow_count; i > pos; i--) begin
					shadow_values[i] = shadow_values[i-1];
					shadow_prios[i]  = shadow_prios[i-1];
				end
				shadow_values[pos] = v;
				shadow_prios[pos]  = p;
				shadow_count++;
				r.ok = 1'b1;
			end
		end else if (shadow_count > 0) begin
			r.ok           = 1'b1;
			r.out_value    = shadow_values[0];
			r.out_priority = shadow_prios[0];
			for (int i = 1; i < shadow_count; i++) begin
				shadow_values[i-1] = shadow_values[i];
				shadow_prios[i-1]  = shadow_prios[i];
			end
			shadow_count--;
		end
		r.entry_count = count_t'(shadow_count);
		r.is_empty    = (shadow_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_response();
		spq_result_t exp_r;
		if (awaited_responses.size() == 0) begin
			report_mismatch("response beat with nothing outstanding");
		end else begin
			exp_r = awaited_responses.pop_front();
			if (rsp_ch.ok !== exp_r.ok)
				report_mismatch($sformatf("ok got %b exp %b", rsp_ch.ok, exp_r.ok));
			if (rsp_ch.out_value !== exp_r.out_value)
				report_mismatch($sformatf("out_value got %0d exp %0d",
					rsp_ch.out_value, exp_r.out_value));
			if (rsp_ch.out_priority !== exp_r.out_priority)
				report_mismatch($sformatf("out_priority got %0d exp %0d",
					rsp_ch.out_priority, exp_r.out_priority));
			if (rsp_ch.entry_count !== exp_r.entry_count)
				report_mismatch($sformatf("entry_count got %0d exp %0d",
					rsp_ch.entry_count, exp_r.entry_count));
			if (rsp_ch.is_empty !== exp_r.is_empty)
				report_mismatch($sformatf("is_empty got %b exp %b",
					rsp_ch.is_empty, exp_r.is_empty));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_response();
			if (req_ch.valid && req_ch.ready)
				awaited_responses.push_back(apply_queue_op(req_ch.action, req_ch.value,
					req_ch.priority_req));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Entered and left at a falling edge; returns once the beat is taken.
	task automatic send_request(input logic act, input value_t v, input prio_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.value        <= v;
		req_ch.priority_req <= p;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic test_empty_dequeue();
		send_request(ACT_DEQ, value_t'(32'h7FFF_FFFF), prio_t'(4'hF));
		send_request(ACT_DEQ, value_t'(32'h8000_0000), prio_t'(4'h0));
	endtask

	// Equal priorities leave in arrival order; extremes of value and priority.
	task automatic test_tie_order();
		send_request(ACT_ENQ, value_t'(100), prio_t'(7));
		send_request(ACT_ENQ, value_t'(32'h8000_0000), prio_t'(0));
		send_request(ACT_ENQ, value_t'(-200), prio_t'(7));
		send_request(ACT_ENQ, value_t'(32'h7FFF_FFFF), prio_t'(15));
		repeat (4)
			send_request(ACT_DEQ, value_t'(0), prio_t'(0));
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < QDEPTH; i++)
			send_request(ACT_ENQ, value_t'($urandom), prio_t'((i * 7) % 16));
		send_request(ACT_ENQ, value_t'(32'h8000_0000), prio_t'(15));
		send_request(ACT_DEQ, value_t'(32'hFFFF_FFFF), prio_t'(15));
	endtask

	// Bursts with a random enqueue bias walk the fill level between empty and full.
	task automatic test_random_traffic(input int beats);
		int     fill_bias;
		logic   act;
		value_t v;
		prio_t  p;
		fill_bias = 50;
		for (int k = 0; k < beats; k++) begin
			if (k % 24 == 0)
				fill_bias = $urandom_range(85, 15);
			act = ($urandom_range(99) < fill_bias) ? ACT_ENQ : ACT_DEQ;
			p = ($urandom_range(3) == 0) ? prio_t'($urandom) : prio_t'($urandom_range(6, 4));
			case ($urandom_range(7))
				0: v = value_t'(32'h8000_0000);
				1: v = value_t'(32'h7FFF_FFFF);
				2: v = value_t'(32'hFFFF_FFFF);
				default: v = value_t'($urandom);
			endcase
			send_request(act, v, p);
		end
	endtask

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.action       = ACT_ENQ;
		req_ch.value        = '0;
		req_ch.priority_req = '0;
		rsp_ch.ready        = 1'b0;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 63;
		test_empty_dequeue();
		test_tie_order();
		test_full_queue();
		test_random_traffic(170);

		send_idle_pct = 63;
		recv_idle_pct = 25;
		test_random_traffic(170);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(170);

		req_ch.valid <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
